@@ sv/gmps_pkg.sv @@
// Shared types and constants for the grid minimum path sum unit.
`timescale 1ns / 1ps
`default_nettype none

package gmps_pkg;

   localparam int COST_W  = 16;
   localparam int COUNT_W = 11;
   localparam int OUT_W   = 27;
   localparam int CSR_INDEX_W = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COLUMN_COUNT = 1'b0,
      CSR_ROW_COUNT    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic first_row;
      logic first_col;
      logic last;
   } cell_tag_type;

endpackage

`default_nettype wire

@@ sv/grid_min_path_sum_unit.sv @@
// Top level of the streaming grid minimum path sum unit.
// Cell costs arrive one per request in raster order, and the unit accepts one
// cell every clock cycle. Each cell's best sum is formed from the row buffer
// entry above it, read from a memory with a registered read port, and the sum
// of the cell to its left. Once the last cell of a grid is accepted and
// registered, its minimum path sum is registered on the result channel. The
// only back pressure on requests comes from the last cell of a grid, which waits
// while a previous result is still held by a stalled result channel. Writing
// either count register starts a new grid and must happen while the unit is idle.
`timescale 1ns / 1ps
`default_nettype none

module grid_min_path_sum_unit
   import gmps_pkg::*;
#(
   parameter int MAX_COLUMNS = 1024,
   parameter int MAX_ROWS = 1024
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [COST_W-1:0]      req_cell_cost,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic      [OUT_W-1:0]       rsp_min_path_sum,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [COUNT_W-1:0]     csr_wdata
);

   localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int SUM_W = COST_W + $clog2(MAX_COLUMNS + MAX_ROWS);
   localparam int EXT_W = (SUM_W > OUT_W) ? SUM_W : OUT_W;
   localparam logic [EXT_W-1:0] OUT_LIMIT = EXT_W'((64'd1 << OUT_W) - 64'd1);

   logic [COUNT_W-1:0] col_cfg_ff, col_cfg_in;
   logic [COUNT_W-1:0] row_cfg_ff, row_cfg_in;
   logic               cfg_write;

   logic               accept;
   logic [COL_W-1:0]   seq_col;
   cell_tag_type       seq_tag;

   logic               s1_valid_ff, s1_valid_in;
   logic [COST_W-1:0]  s1_cost_ff;
   cell_tag_type       s1_tag_ff;
   logic [COL_W-1:0]   s1_addr_ff;
   logic               s1_fwd_ff, s1_fwd_in;
   logic [SUM_W-1:0]   s1_fwd_data_ff;
   logic               s1_fire;

   logic [SUM_W-1:0]   left_ff, left_in;
   logic [SUM_W-1:0]   mem_rdata;
   logic [SUM_W-1:0]   above;
   logic [SUM_W-1:0]   addend;
   logic [SUM_W-1:0]   sum;
   logic [EXT_W-1:0]   sum_ext;

   logic               out_free;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]   rsp_data_ff, rsp_data_in;

   assign csr_ready = 1'b1;
   assign cfg_write = csr_valid && csr_ready;

   always_comb begin
      col_cfg_in = col_cfg_ff;
      row_cfg_in = row_cfg_ff;
      if (cfg_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_COLUMN_COUNT: col_cfg_in = csr_wdata;
            CSR_ROW_COUNT:    row_cfg_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cfg_ff <= COUNT_W'(1);
         row_cfg_ff <= COUNT_W'(1);
      end else begin
         col_cfg_ff <= col_cfg_in;
         row_cfg_ff <= row_cfg_in;
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && (!s1_tag_ff.last || out_free);
   assign req_stall = s1_valid_ff && !s1_fire;
   assign accept    = req_valid && !req_stall;

   gmps_seq #(
      .MAX_COLUMNS(MAX_COLUMNS),
      .MAX_ROWS(MAX_ROWS),
      .COL_W(COL_W),
      .ROW_W(ROW_W)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .restart(cfg_write),
      .accept(accept),
      .col_cfg(col_cfg_ff),
      .row_cfg(row_cfg_ff),
      .col(seq_col),
      .tag(seq_tag)
   );

   gmps_row_mem #(
      .DEPTH(MAX_COLUMNS),
      .WIDTH(SUM_W),
      .ADDR_W(COL_W)
   ) u_row_mem (
      .clock(clock),
      .wr_en(s1_fire),
      .wr_addr(s1_addr_ff),
      .wr_data(sum),
      .rd_en(accept),
      .rd_addr(seq_col),
      .rd_data(mem_rdata)
   );

   always_comb begin
      above = s1_fwd_ff ? s1_fwd_data_ff : mem_rdata;
      priority if (s1_tag_ff.first_row && s1_tag_ff.first_col) begin
         addend = '0;
      end else if (s1_tag_ff.first_row) begin
         addend = left_ff;
      end else if (s1_tag_ff.first_col) begin
         addend = above;
      end else begin
         addend = (above < left_ff) ? above : left_ff;
      end
      sum = SUM_W'(s1_cost_ff) + addend;
      sum_ext = EXT_W'(sum);
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      s1_fwd_in = s1_fire && (s1_addr_ff == seq_col);
      left_in = left_ff;
      if (cfg_write) begin
         left_in = '0;
      end else if (s1_fire) begin
         left_in = sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         left_ff     <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         left_ff     <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cost_ff     <= req_cell_cost;
         s1_tag_ff      <= seq_tag;
         s1_addr_ff     <= seq_col;
         s1_fwd_ff      <= s1_fwd_in;
         s1_fwd_data_ff <= sum;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_fire && s1_tag_ff.last) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = (sum_ext > OUT_LIMIT) ? OUT_LIMIT[OUT_W-1:0] : sum_ext[OUT_W-1:0];
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_min_path_sum = rsp_data_ff;

endmodule

`default_nettype wire

@@ sv/gmps_row_mem.sv @@
// Row buffer memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module gmps_row_mem #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 27,
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/gmps_seq.sv @@
// Raster position sequencer that tags each incoming cell with its place in the grid.
`timescale 1ns / 1ps
`default_nettype none

module gmps_seq
   import gmps_pkg::*;
#(
   parameter int MAX_COLUMNS = 1024,
   parameter int MAX_ROWS = 1024,
   parameter int COL_W = 10,
   parameter int ROW_W = 10
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               restart,
   input  wire logic               accept,
   input  wire logic [COUNT_W-1:0] col_cfg,
   input  wire logic [COUNT_W-1:0] row_cfg,
   output logic      [COL_W-1:0]   col,
   output cell_tag_type            tag
);

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] last_col;
   logic [ROW_W-1:0] last_row;

   always_comb begin
      if (col_cfg == '0) begin
         last_col = '0;
      end else if (32'(col_cfg) > MAX_COLUMNS) begin
         last_col = COL_W'(MAX_COLUMNS - 1);
      end else begin
         last_col = COL_W'(col_cfg - COUNT_W'(1));
      end
      if (row_cfg == '0) begin
         last_row = '0;
      end else if (32'(row_cfg) > MAX_ROWS) begin
         last_row = ROW_W'(MAX_ROWS - 1);
      end else begin
         last_row = ROW_W'(row_cfg - COUNT_W'(1));
      end
   end

   always_comb begin
      tag.first_row = (row_ff == '0);
      tag.first_col = (col_ff == '0);
      tag.last      = (row_ff == last_row) && (col_ff == last_col);
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == last_col) begin
            col_in = '0;
            row_in = (row_ff == last_row) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign col = col_ff;

endmodule

`default_nettype wire

@@ sv/gmps_checker.sv @@
// Port-level assertions for the grid minimum path sum unit and their bind.
`timescale 1ns / 1ps
`default_nettype none

module gmps_checker
   import gmps_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire logic [OUT_W-1:0] rsp_min_path_sum
);

   // A result that is not taken stays on the channel.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // The path sum of a stalled result does not change.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_min_path_sum))
      else $error("result changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Requests are held back only by a result that cannot leave.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a blocked result");

   // A new result follows an accepted request through the stage and result registers.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a matching request");

endmodule

bind grid_min_path_sum_unit gmps_checker u_gmps_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_min_path_sum(rsp_min_path_sum)
);

`default_nettype wire
